// ===== rtl/rpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpi_pkg
// Shared types and constants of the ray / parallelogram intersection block.
// ---------------------------------------------------------------------------
package rpi_pkg;

  localparam int NumRegs      = 7;
  localparam int RegIdxW      = 3;
  localparam int CfgW         = 64;
  localparam int ParallelLim  = 1074;
  localparam int QueueDepth   = 4;
  localparam int QueueIdxW    = 2;
  localparam int DivSteps     = 32;

  typedef enum logic [RegIdxW-1:0] {
    REG_CORNER_XY   = 3'd0,
    REG_CORNER_Z_AX = 3'd1,
    REG_EDGE_A_YZ   = 3'd2,
    REG_EDGE_B_XY   = 3'd3,
    REG_EDGE_B_Z_NX = 3'd4,
    REG_NORMAL_YZ   = 3'd5,
    REG_INV_LEN_SQ  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic signed [31:0] near_distance;
    logic signed [31:0] far_distance;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic [16:0]        coord_u;
    logic [16:0]        coord_v;
    logic               back_side;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } result_t;

  // Parallelogram as read from the configuration registers.
  typedef struct packed {
    logic signed [31:0] cx, cy, cz;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] bx, by, bz;
    logic signed [31:0] nx, ny, nz;
    logic [31:0]        ia, ib;
  } shape_t;

  // Classified ray passed from the front to the back end.
  typedef struct packed {
    logic               live;       // not parallel
    logic               back_side;
    logic [61:0]        num_mag;
    logic [61:0]        den_mag;
    logic               neg;
    ray_t               ray;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -34'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat32_wide(input logic signed [48:0] x);
    if (x > 49'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -49'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpi_if
// Valid / ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface rpi_ray_if;
  import rpi_pkg::*;
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpi_res_if;
  import rpi_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ray_parallelogram_intersect_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ray_parallelogram_intersect_core
// Tests rays against one configured parallelogram in Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Rays enter on the ray channel, one word per ray; results leave on the
// result channel, one word per ray, in order. The parallelogram is written
// through the register port (we, idx, wdata); the user must write it only
// while no ray is in flight, which the block does not enforce. A front end
// of two stages forms the plane dot products and classifies the ray; a
// four-entry queue decouples it from the back end, which is a pipelined
// divider of 32 one-bit stages followed by six stages of hit point and
// projection math. Every stage, the divider included, takes a new ray each
// cycle, so throughput is one ray per clock; when the receiver stalls the
// back end holds, the queue fills, and then the front end stops taking rays.
// Reset clears the configuration registers, queue state and valid flags.
// ---------------------------------------------------------------------------
module ray_parallelogram_intersect_core
  import rpi_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [RegIdxW-1:0] idx,
  input  wire logic [CfgW-1:0]    wdata,
  rpi_ray_if.sink            ray_in,
  rpi_res_if.source          res_out
);

  logic [CfgW-1:0] regs [NumRegs];
  shape_t          shape;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (we && idx < RegIdxW'(NumRegs)) begin
      regs[idx] <= wdata;
    end
  end

  always_comb begin
    shape.cx = regs[REG_CORNER_XY][31:0];
    shape.cy = regs[REG_CORNER_XY][63:32];
    shape.cz = regs[REG_CORNER_Z_AX][31:0];
    shape.ax = regs[REG_CORNER_Z_AX][63:32];
    shape.ay = regs[REG_EDGE_A_YZ][31:0];
    shape.az = regs[REG_EDGE_A_YZ][63:32];
    shape.bx = regs[REG_EDGE_B_XY][31:0];
    shape.by = regs[REG_EDGE_B_XY][63:32];
    shape.bz = regs[REG_EDGE_B_Z_NX][31:0];
    shape.nx = regs[REG_EDGE_B_Z_NX][63:32];
    shape.ny = regs[REG_NORMAL_YZ][31:0];
    shape.nz = regs[REG_NORMAL_YZ][63:32];
    shape.ia = regs[REG_INV_LEN_SQ][31:0];
    shape.ib = regs[REG_INV_LEN_SQ][63:32];
  end

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  rpi_front u_front (
    .clk, .rst, .shape,
    .in_valid(ray_in.valid), .in_ready(ray_in.ready), .in_ray(ray_in.data),
    .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
  );

  rpi_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  rpi_back u_back (
    .clk, .rst, .shape,
    .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
    .out_valid(res_out.valid), .out_ready(res_out.ready), .out_res(res_out.data)
  );

endmodule

`default_nettype wire

// ===== rtl/rpi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpi_front
// Front end: two pipeline stages form the plane dot products and classify
// each ray as parallel or live, with quotient magnitudes and sign.
// ---------------------------------------------------------------------------
module rpi_front
  import rpi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire shape_t shape,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire ray_t   in_ray,
  output logic        out_valid,
  input  wire logic   out_ready,
  output job_t        out_job
);

  logic        v1;
  ray_t        r1;
  logic signed [63:0] pd [3];
  logic signed [63:0] pn [3];
  logic        adv1, adv2;
  logic signed [64:0] den, num;
  logic signed [31:0] w [3];

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    w[0] = sat32(34'(shape.cx) - 34'(in_ray.origin_x));
    w[1] = sat32(34'(shape.cy) - 34'(in_ray.origin_y));
    w[2] = sat32(34'(shape.cz) - 34'(in_ray.origin_z));
  end

  // Stage 1: six products, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      r1    <= in_ray;
      pd[0] <= in_ray.direction_x * shape.nx;
      pd[1] <= in_ray.direction_y * shape.ny;
      pd[2] <= in_ray.direction_z * shape.nz;
      pn[0] <= w[0] * shape.nx;
      pn[1] <= w[1] * shape.ny;
      pn[2] <= w[2] * shape.nz;
    end
  end

  // Stage 2: floor-shifted sums and classification.
  always_comb begin
    den = 65'(pd[0] >>> 2) + 65'(pd[1] >>> 2) + 65'(pd[2] >>> 2);
    num = 65'(pn[0] >>> 2) + 65'(pn[1] >>> 2) + 65'(pn[2] >>> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= v1;
    end
    if (adv2) begin
      out_job.live      <= !(den > -65'sd1074 && den < 65'sd1074);
      out_job.back_side <= !den[64];
      out_job.neg       <= num[64] != den[64];
      out_job.num_mag   <= num[64] ? 62'(-num) : num[61:0];
      out_job.den_mag   <= den[64] ? 62'(-den) : den[61:0];
      out_job.ray       <= r1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpi_queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
module rpi_queue
  import rpi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire job_t in_job,
  output logic      out_valid,
  input  wire logic out_ready,
  output job_t      out_job
);

  job_t                mem [QueueDepth];
  logic [QueueIdxW-1:0] wp, rp;
  logic [QueueIdxW:0]   cnt;
  logic                 push, pop;

  assign in_ready  = cnt != (QueueIdxW+1)'(QueueDepth);
  assign out_valid = cnt != '0;
  assign out_job   = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QueueIdxW+1)'(push) - (QueueIdxW+1)'(pop);
    end
    if (push) mem[wp] <= in_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == (QueueIdxW+1)'(QueueDepth) |-> !push)
    else $error("queue overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QueueIdxW+1)'(QueueDepth))
    else $error("queue count out of range");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/rpi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpi_back
// Back end: pipelined restoring divider (one quotient bit per stage), then
// hit point, edge projections, exact range tests; one ray per unstalled cycle.
// ---------------------------------------------------------------------------
module rpi_back
  import rpi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire shape_t  shape,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire job_t    in_job,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  localparam int NS = DivSteps + 6;

  // The whole pipeline advances together; the last stage is the output.
  logic adv;
  logic [NS-1:0] v;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = v[NS-1];

  // Divider: the dividend is num_mag * 2^16. Its upper part num_mag[61:16]
  // seeds the remainder and the 32 low bits enter one per stage; dx holds
  // the dividend bits still to come above the quotient bits found so far.
  // A seed at or above the divisor means a quotient of 2^32 or more, which
  // no interval can hold, so such a ray is marked dead at the first stage.
  job_t        dj     [DivSteps];
  logic [61:0] drem   [DivSteps];
  logic [31:0] dx     [DivSteps];
  job_t        sjob   [DivSteps];
  logic [61:0] srem   [DivSteps];
  logic [31:0] sx     [DivSteps];
  logic [63:0] strial [DivSteps];

  always_comb begin
    sjob[0]      = in_job;
    sjob[0].live = in_job.live && ({16'd0, in_job.num_mag[61:16]} < in_job.den_mag);
    srem[0]      = {16'd0, in_job.num_mag[61:16]};
    sx[0]        = {in_job.num_mag[15:0], 16'd0};
    for (int i = 1; i < DivSteps; i++) begin
      sjob[i] = dj[i-1];
      srem[i] = drem[i-1];
      sx[i]   = dx[i-1];
    end
    for (int i = 0; i < DivSteps; i++) begin
      strial[i] = {1'b0, srem[i], sx[i][31]} - {2'b00, sjob[i].den_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DivSteps; i++) begin
        dj[i] <= sjob[i];
        if (!strial[i][63]) begin
          drem[i] <= strial[i][61:0];
          dx[i]   <= {sx[i][30:0], 1'b1};
        end else begin
          drem[i] <= {srem[i][60:0], sx[i][31]};
          dx[i]   <= {sx[i][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[NS-2:0], in_valid};
  end

  // Stage A: sign and range check against the interval; stage B forms t*D.
  logic               a_ok;
  logic signed [31:0] a_t;
  ray_t               a_r;
  logic               a_bs;
  logic [31:0]        qd;
  logic signed [32:0] ts;
  assign qd = dx[DivSteps-1];
  assign ts = dj[DivSteps-1].neg ? -33'(qd) : 33'(qd);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= dj[DivSteps-1].ray;
      a_bs <= dj[DivSteps-1].back_side;
      a_t  <= ts[31:0];
      a_ok <= dj[DivSteps-1].live
              && !(ts < 33'(dj[DivSteps-1].ray.near_distance))
              && !(ts > 33'(dj[DivSteps-1].ray.far_distance));
    end
  end

  logic signed [63:0] b_td [3];
  logic               b_ok, b_bs;
  logic signed [31:0] b_t;
  ray_t               b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_td[0] <= a_t * a_r.direction_x;
      b_td[1] <= a_t * a_r.direction_y;
      b_td[2] <= a_t * a_r.direction_z;
      b_ok <= a_ok; b_bs <= a_bs; b_t <= a_t; b_r <= a_r;
    end
  end

  // Stage C: hit point and offset from corner.
  logic signed [31:0] qc [3];
  logic signed [31:0] wc [3];
  always_comb begin
    qc[0] = sat32_wide(49'(b_r.origin_x) + 49'(b_td[0] >>> 16));
    qc[1] = sat32_wide(49'(b_r.origin_y) + 49'(b_td[1] >>> 16));
    qc[2] = sat32_wide(49'(b_r.origin_z) + 49'(b_td[2] >>> 16));
    wc[0] = sat32(34'(qc[0]) - 34'(shape.cx));
    wc[1] = sat32(34'(qc[1]) - 34'(shape.cy));
    wc[2] = sat32(34'(qc[2]) - 34'(shape.cz));
  end

  logic signed [31:0] c_q [3];
  logic signed [31:0] c_w [3];
  logic               c_ok, c_bs;
  logic signed [31:0] c_t;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_q <= qc; c_w <= wc; c_ok <= b_ok; c_bs <= b_bs; c_t <= b_t;
    end
  end

  // Stage D: edge products.
  logic signed [63:0] d_pa [3];
  logic signed [63:0] d_pb [3];
  logic signed [31:0] d_q [3];
  logic               d_ok, d_bs;
  logic signed [31:0] d_t;
  always_ff @(posedge clk) begin
    if (adv) begin
      d_pa[0] <= c_w[0] * shape.ax; d_pa[1] <= c_w[1] * shape.ay;
      d_pa[2] <= c_w[2] * shape.az;
      d_pb[0] <= c_w[0] * shape.bx; d_pb[1] <= c_w[1] * shape.by;
      d_pb[2] <= c_w[2] * shape.bz;
      d_q <= c_q; d_ok <= c_ok; d_bs <= c_bs; d_t <= c_t;
    end
  end

  // Stage E: dot sums and their products with the reciprocals, split 32x32.
  logic signed [64:0] da, db;
  always_comb begin
    da = 65'(d_pa[0] >>> 2) + 65'(d_pa[1] >>> 2) + 65'(d_pa[2] >>> 2);
    db = 65'(d_pb[0] >>> 2) + 65'(d_pb[1] >>> 2) + 65'(d_pb[2] >>> 2);
  end

  logic [63:0] e_ahi, e_alo, e_bhi, e_blo;
  logic        e_an, e_bn;
  logic signed [31:0] e_q [3];
  logic        e_ok, e_bs;
  logic signed [31:0] e_t;
  always_ff @(posedge clk) begin
    if (adv) begin
      e_ahi <= 64'(da[63:32]) * 64'(shape.ia);
      e_alo <= 64'(da[31:0]) * 64'(shape.ia);
      e_bhi <= 64'(db[63:32]) * 64'(shape.ib);
      e_blo <= 64'(db[31:0]) * 64'(shape.ib);
      e_an <= da[64]; e_bn <= db[64];
      e_q <= d_q; e_ok <= d_ok; e_bs <= d_bs; e_t <= d_t;
    end
  end

  // Final stage: exact compare against one and output register.
  logic [64:0] ca, cb;
  logic        ua, ub;
  always_comb begin
    ca = 65'(e_ahi) + 65'(e_alo[63:32]);
    cb = 65'(e_bhi) + 65'(e_blo[63:32]);
    ua = shape.ia == '0 || (!e_an && (ca < 65'h10000000
         || (ca == 65'h10000000 && e_alo[31:0] == '0)));
    ub = shape.ib == '0 || (!e_bn && (cb < 65'h10000000
         || (cb == 65'h10000000 && e_blo[31:0] == '0)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (e_ok && ua && ub) begin
        out_res.hit          <= 1'b1;
        out_res.hit_distance <= e_t;
        out_res.coord_u      <= shape.ia == '0 ? 17'd0 : ca[28:12];
        out_res.coord_v      <= shape.ib == '0 ? 17'd0 : cb[28:12];
        out_res.back_side    <= e_bs;
        out_res.point_x      <= e_q[0];
        out_res.point_y      <= e_q[1];
        out_res.point_z      <= e_q[2];
      end else begin
        out_res <= '0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.hit |-> out_res.hit_distance == '0 && !out_res.back_side)
    else $error("miss carries data");
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.coord_u <= 17'd65536 && out_res.coord_v <= 17'd65536)
    else $error("coordinate out of range");

endmodule

`default_nettype wire
